// ===== design/imuq_pkg.sv =====
package imuq_pkg;

   localparam logic [23:0] HDR_PREFIX = 24'h5A5A10;
   localparam logic [7:0]  HDR_LAST   = 8'h09;
   localparam logic [7:0]  HDR_SUM    = 8'hCD;

   localparam logic [3:0] FIRST_PAYLOAD_POS = 4'd4;
   localparam logic [3:0] CHECKSUM_POS      = 4'd13;
   localparam int         PAYLOAD_LEN       = 9;

   localparam logic [32:0] MAG_LOW_RESET  = 33'd90000000;
   localparam logic [32:0] MAG_HIGH_RESET = 33'd110000000;

   localparam logic REG_MAG_LOW  = 1'b0;
   localparam logic REG_MAG_HIGH = 1'b1;

   localparam logic [1:0] STATUS_GOOD      = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM  = 2'd1;
   localparam logic [1:0] STATUS_MAGNITUDE = 2'd2;

   typedef struct packed {
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_w;
      logic [7:0]         accuracy;
      logic               checksum_ok;
   } frame_entry_type;

   typedef struct packed {
      logic [7:0]         accuracy;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_w;
      logic [1:0]         frame_status;
   } frame_result_type;

endpackage

// ===== design/imu_quaternion_frame_parser_unit.sv =====
// Channel  Direction  Item                      Handshake
// req      in         one received serial byte  req_tvalid / req_tready
// rsp      out        one decoded frame         rsp_tvalid / rsp_tready
// csr      in         bound register write      csr_wen, no wait
//
// One byte is taken every cycle; only the checksum byte waits, and only when
// the frame queue is full. After its checksum byte is taken, a frame passes
// through the queue and the three-stage square, sum and compare pipeline.
// Reset is synchronous and clears the header hunt, the queue and the pipeline.
// A stalled result side fills the pipeline and then the queue before the
// input side holds at the next checksum byte.
module imu_quaternion_frame_parser_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // quat_w, quat_x, quat_y, quat_z, accuracy
   output logic [1:0]  rsp_tuser,   // [1:0] frame_status
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [32:0] csr_wdata
);

   logic [32:0] mag_low_ff, mag_low_in;
   logic [32:0] mag_high_ff, mag_high_in;

   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   imuq_pkg::frame_entry_type  push_entry, pop_entry;
   imuq_pkg::frame_result_type result;

   always_comb begin
      mag_low_in  = mag_low_ff;
      mag_high_in = mag_high_ff;
      if (csr_wen) begin
         case (csr_index)
            imuq_pkg::REG_MAG_LOW:  mag_low_in  = csr_wdata;
            imuq_pkg::REG_MAG_HIGH: mag_high_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_low_ff  <= imuq_pkg::MAG_LOW_RESET;
         mag_high_ff <= imuq_pkg::MAG_HIGH_RESET;
      end else begin
         mag_low_ff  <= mag_low_in;
         mag_high_ff <= mag_high_in;
      end
   end

   imuq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   imuq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   imuq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mag_low    (mag_low_ff),
      .mag_high   (mag_high_ff),
      .in_valid   (pop_valid),
      .in_ready   (pop_ready),
      .in_entry   (pop_entry),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.accuracy, result.quat_z, result.quat_y,
                       result.quat_x, result.quat_w};
   assign rsp_tuser = result.frame_status;

endmodule

// ===== design/imuq_front.sv =====
module imuq_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   output logic                      push_valid,
   input  logic                      push_ready,
   output imuq_pkg::frame_entry_type push_entry
);

   logic [23:0] window_ff, window_in;
   logic        in_frame_ff, in_frame_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  payload_ff [imuq_pkg::PAYLOAD_LEN];
   logic        collect;
   logic        accept;
   logic [3:0]  slot;

   assign collect = (pos_ff >= imuq_pkg::FIRST_PAYLOAD_POS) &&
                    (pos_ff < imuq_pkg::CHECKSUM_POS);
   assign push_valid = req_tvalid && in_frame_ff && !collect;
   assign req_tready = !(in_frame_ff && !collect) || push_ready;
   assign accept = req_tvalid && req_tready;
   assign slot = pos_ff - imuq_pkg::FIRST_PAYLOAD_POS;

   always_comb begin
      push_entry.quat_w      = {payload_ff[0], payload_ff[1]};
      push_entry.quat_x      = {payload_ff[2], payload_ff[3]};
      push_entry.quat_y      = {payload_ff[4], payload_ff[5]};
      push_entry.quat_z      = {payload_ff[6], payload_ff[7]};
      push_entry.accuracy    = payload_ff[8];
      push_entry.checksum_ok = (sum_ff == req_tdata);
   end

   always_comb begin
      window_in   = window_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (window_ff == imuq_pkg::HDR_PREFIX && req_tdata == imuq_pkg::HDR_LAST) begin
               in_frame_in = 1'b1;
               pos_in      = imuq_pkg::FIRST_PAYLOAD_POS;
               sum_in      = imuq_pkg::HDR_SUM;
               window_in   = '0;
            end else begin
               window_in = {window_ff[15:0], req_tdata};
            end
         end else if (collect) begin
            sum_in = sum_ff + req_tdata;
            pos_in = pos_ff + 4'd1;
         end else begin
            in_frame_in = 1'b0;
            pos_in      = '0;
            sum_in      = '0;
            window_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         sum_ff      <= '0;
      end else begin
         window_ff   <= window_in;
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_frame_ff && collect) begin
         payload_ff[slot] <= req_tdata;
      end
   end

endmodule

// ===== design/imuq_queue.sv =====
module imuq_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  imuq_pkg::frame_entry_type push_entry,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output imuq_pkg::frame_entry_type pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   imuq_pkg::frame_entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/imuq_back.sv =====
module imuq_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [32:0]                mag_low,
   input  logic [32:0]                mag_high,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  imuq_pkg::frame_entry_type  in_entry,
   output logic                       out_valid,
   input  logic                       out_ready,
   output imuq_pkg::frame_result_type out_result
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic ready1, ready2, ready3;

   imuq_pkg::frame_entry_type e1_ff, e2_ff;
   logic [30:0] sq_w_ff, sq_x_ff, sq_y_ff, sq_z_ff;
   logic [31:0] sum_a_ff, sum_b_ff;
   imuq_pkg::frame_result_type res_ff;

   logic signed [31:0] prod_w, prod_x, prod_y, prod_z;
   logic [32:0]        total;
   logic [1:0]         status;

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   assign prod_w = 32'(in_entry.quat_w) * 32'(in_entry.quat_w);
   assign prod_x = 32'(in_entry.quat_x) * 32'(in_entry.quat_x);
   assign prod_y = 32'(in_entry.quat_y) * 32'(in_entry.quat_y);
   assign prod_z = 32'(in_entry.quat_z) * 32'(in_entry.quat_z);

   assign total = {1'b0, sum_a_ff} + {1'b0, sum_b_ff};

   always_comb begin
      if (!e2_ff.checksum_ok) begin
         status = imuq_pkg::STATUS_CHECKSUM;
      end else if ((mag_low < total) && (total < mag_high)) begin
         status = imuq_pkg::STATUS_GOOD;
      end else begin
         status = imuq_pkg::STATUS_MAGNITUDE;
      end
   end

   always_comb begin
      v1_in = ready1 ? in_valid : v1_ff;
      v2_in = ready2 ? v1_ff : v2_ff;
      v3_in = ready3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         e1_ff   <= in_entry;
         sq_w_ff <= prod_w[30:0];
         sq_x_ff <= prod_x[30:0];
         sq_y_ff <= prod_y[30:0];
         sq_z_ff <= prod_z[30:0];
      end
      if (ready2) begin
         e2_ff    <= e1_ff;
         sum_a_ff <= {1'b0, sq_w_ff} + {1'b0, sq_x_ff};
         sum_b_ff <= {1'b0, sq_y_ff} + {1'b0, sq_z_ff};
      end
      if (ready3) begin
         res_ff.quat_w       <= e2_ff.quat_w;
         res_ff.quat_x       <= e2_ff.quat_x;
         res_ff.quat_y       <= e2_ff.quat_y;
         res_ff.quat_z       <= e2_ff.quat_z;
         res_ff.accuracy     <= e2_ff.accuracy;
         res_ff.frame_status <= status;
      end
   end

   assign out_valid  = v3_ff;
   assign out_result = res_ff;

endmodule
